/* design/fbfl_pkg.sv */
// fbfl_pkg: shared types and constants of the fixed block free list allocator
// no dependencies; imported by the divider, top level and checker
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

	// field and register widths
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned REQ_W      = 16;
	localparam int unsigned CSIZE_W    = 13;
	localparam int unsigned TOTAL_W    = 11;
	localparam int unsigned SIZE_W     = 14;
	localparam int unsigned STAT_W     = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// chunk size rounding
	localparam logic [SIZE_W-1:0] ALIGN_ADD  = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] ALIGN_MASK = ~SIZE_W'(3);
	localparam logic [SIZE_W-1:0] MIN_CHUNK  = SIZE_W'(8);

	// configuration reset values
	localparam logic [CSIZE_W-1:0] CSIZE_RST = CSIZE_W'(36);
	localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(10);
	localparam logic [ADDR_W-1:0]  BASE_RST  = '0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		STS_ALLOCATED  = 3'd0,
		STS_TOO_LARGE  = 3'd1,
		STS_EXHAUSTED  = 3'd2,
		STS_FREED      = 3'd3,
		STS_NULL       = 3'd4,
		STS_OUT_RANGE  = 3'd5,
		STS_MISALIGNED = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC,
		ST_RANGE,
		ST_DIV,
		ST_DONE
	} state_t;

	// divider handshake
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

`default_nettype wire

/* design/fbfl_ram.sv */
// fbfl_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fbfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/fbfl_div.sv */
// fbfl_div: iterative restoring divider, one quotient bit per cycle
// depends on fbfl_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module fbfl_div #(
	parameter int unsigned DW = 32,
	parameter int unsigned VW = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DW-1:0]      dividend,
	input  wire logic [VW-1:0]      divisor,
	output fbfl_pkg::div_sts_t      sts,
	output logic      [DW-1:0]      quotient,
	output logic      [VW-1:0]      remainder
);

	import fbfl_pkg::*;

	localparam int unsigned CNT_W = $clog2(DW);

	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      shifted;
	logic [VW:0]      diff;

	assign shifted = {rem_q, dvd_q[DW-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// no borrow: subtract and shift in a one
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* design/fixed_block_free_list_allocator_top.sv */
// fixed block pool allocator: lifo free list of chunk indices in a ram
// an allocate passes decode and alloc, a free in range decode, range and the 32 divider
// steps, other rejected items stop after decode or range; one item in flight, the next is
// taken in the cycle after its result loads; a stalled result holds it
// reset and every write to a defined configuration register run a relink sweep over all
// MAX_CHUNKS link entries, during which no transaction is accepted; uses fbfl_pkg, fbfl_ram, fbfl_div
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator_top #(
	parameter int unsigned MAX_CHUNKS = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                mode,
	input  wire logic [fbfl_pkg::REQ_W-1:0]          request_size,
	input  wire logic                                null_pointer,
	input  wire logic [fbfl_pkg::ADDR_W-1:0]         free_address,
	// result channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [fbfl_pkg::STAT_W-1:0]         status,
	output logic      [fbfl_pkg::ADDR_W-1:0]         chunk_address,
	output logic      [fbfl_pkg::TOTAL_W-1:0]        free_count
);

	import fbfl_pkg::*;

	// chunk index width and the largest usable chunk count
	localparam int unsigned IW    = $clog2(MAX_CHUNKS);
	localparam int unsigned CAP   = (MAX_CHUNKS < 2047) ? MAX_CHUNKS : 2047;
	localparam int unsigned MB_W  = (IW > TOTAL_W) ? IW : TOTAL_W;
	localparam int unsigned PW    = SIZE_W + MB_W;
	localparam int unsigned LINK_W = IW + 1;

	// configuration registers
	logic [CSIZE_W-1:0] csize_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  base_q;
	logic               cfg_hit;

	// sequencer and list state
	state_t             state_q, state_d;
	logic [IW-1:0]      head_q;
	logic               head_vld_q;
	logic [TOTAL_W-1:0] count_q;
	logic [IW-1:0]      clr_q;

	// latched transaction
	logic               mode_q;
	logic [REQ_W-1:0]   req_q;
	logic               null_q;
	logic [ADDR_W-1:0]  addr_q;

	// working registers
	logic [PW-1:0]      prod_q;
	status_t            res_status_q;
	logic [ADDR_W-1:0]  res_addr_q;

	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [TOTAL_W-1:0] out_count_q;

	// derived configuration
	logic [SIZE_W-1:0]  size_round;
	logic [SIZE_W-1:0]  eff_size;
	logic [TOTAL_W-1:0] eff_total;

	// datapath signals
	logic [MB_W-1:0]    mul_b;
	logic [ADDR_W:0]    pool_end;
	logic               in_range;
	logic               sweep_last;
	logic               too_large;
	logic               div_fail;
	logic               done_load;

	// ram and divider hookup
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [LINK_W-1:0]  ram_wdata;
	logic [LINK_W-1:0]  ram_rdata;
	logic               div_start;
	div_sts_t           div_sts;
	logic [ADDR_W-1:0]  div_quot;
	logic [SIZE_W-1:0]  div_rem;

	assign cfg_hit = cfg_we && (cfg_index == CFG_CHUNK_SIZE || cfg_index == CFG_TOTAL
		|| cfg_index == CFG_BASE);

	// effective chunk size: round up to four, at least eight
	assign size_round = (SIZE_W'(csize_q) + ALIGN_ADD) & ALIGN_MASK;
	assign eff_size   = (size_round < MIN_CHUNK) ? MIN_CHUNK : size_round;
	assign eff_total  = (32'(total_q) > CAP) ? TOTAL_W'(CAP) : total_q;

	// shared multiplier operand: head index for allocate, chunk count for free
	assign mul_b = mode_q ? MB_W'(eff_total) : MB_W'(head_q);

	// exact pool end, no wrap
	assign pool_end = {1'b0, base_q} + (ADDR_W + 1)'(prod_q);
	assign in_range = (addr_q >= base_q) && ({1'b0, addr_q} < pool_end);

	assign sweep_last = (clr_q == IW'(MAX_CHUNKS - 1));
	assign too_large  = (req_q > REQ_W'(eff_size));
	assign div_fail   = (div_rem != '0) || (div_quot >= ADDR_W'(MAX_CHUNKS));
	assign done_load  = !out_valid_q || out_ready;

	fbfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_CHUNKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	fbfl_div #(
		.DW(ADDR_W),
		.VW(SIZE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (addr_q - base_q),
		.divisor   (eff_size),
		.sts       (div_sts),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (sweep_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (!mode_q) begin
					state_d = (too_large || !head_vld_q) ? ST_DONE : ST_ALLOC;
				end else begin
					state_d = null_q ? ST_DONE : ST_RANGE;
				end
			end
			ST_ALLOC:  state_d = ST_DONE;
			ST_RANGE:  state_d = in_range ? ST_DIV : ST_DONE;
			ST_DIV:    if (div_sts.done) state_d = ST_DONE;
			ST_DONE:   if (done_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		// any write to a defined register starts a fresh relink
		if (cfg_hit) begin
			state_d = ST_CLEAR;
		end
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// chunk i links i+1, valid unless it is the last chunk
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {(32'(clr_q) + 32'd1 < 32'(eff_total)), IW'(clr_q + IW'(1))};
			end
			ST_IDLE:   in_ready = 1'b1;
			ST_RANGE:  div_start = in_range;
			ST_DIV: begin
				// push the freed chunk on the head
				ram_we    = div_sts.done && !div_fail;
				ram_waddr = div_quot[IW-1:0];
				ram_wdata = {head_vld_q, head_q};
			end
			ST_DECODE, ST_ALLOC, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q <= CSIZE_RST;
			total_q <= TOTAL_RST;
			base_q  <= BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHUNK_SIZE: csize_q <= cfg_data[CSIZE_W-1:0];
				CFG_TOTAL:      total_q <= cfg_data[TOTAL_W-1:0];
				CFG_BASE:       base_q  <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer state, list head and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			head_vld_q <= 1'b0;
			count_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_hit) begin
				clr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
				if (sweep_last) begin
					head_q     <= '0;
					head_vld_q <= (eff_total != '0);
					count_q    <= eff_total;
				end
			end
			// pop on allocate
			if (state_q == ST_ALLOC) begin
				head_q     <= ram_rdata[IW-1:0];
				head_vld_q <= ram_rdata[IW];
				if (count_q != '0) begin
					count_q <= count_q - TOTAL_W'(1);
				end
			end
			// push on free
			if (state_q == ST_DIV && div_sts.done && !div_fail) begin
				head_q     <= div_quot[IW-1:0];
				head_vld_q <= 1'b1;
				if (count_q < eff_total) begin
					count_q <= count_q + TOTAL_W'(1);
				end
			end
			if (state_q == ST_DONE && done_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode;
			req_q  <= request_size;
			null_q <= null_pointer;
			addr_q <= free_address;
		end
		unique case (state_q)
			ST_DECODE: begin
				prod_q     <= PW'(eff_size) * PW'(mul_b);
				res_addr_q <= '0;
				if (!mode_q) begin
					res_status_q <= too_large ? STS_TOO_LARGE : STS_EXHAUSTED;
				end else begin
					res_status_q <= STS_NULL;
				end
			end
			ST_ALLOC: begin
				res_status_q <= STS_ALLOCATED;
				res_addr_q   <= base_q + ADDR_W'(prod_q);
			end
			ST_RANGE: res_status_q <= STS_OUT_RANGE;
			ST_DIV: res_status_q <= div_fail ? STS_MISALIGNED : STS_FREED;
			ST_DONE: begin
				if (done_load) begin
					out_status_q <= res_status_q;
					out_addr_q   <= res_addr_q;
					out_count_q  <= count_q;
				end
			end
			ST_CLEAR, ST_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign chunk_address = out_addr_q;
	assign free_count    = out_count_q;

endmodule

`default_nettype wire

/* design/fbfl_chk.sv */
// fbfl_chk: port level checks of the allocator, bound to the top level
// depends on fbfl_pkg for status and register index codes
`timescale 1ns / 1ps
`default_nettype none

module fbfl_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                cfg_we,
	input wire logic [fbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic [fbfl_pkg::STAT_W-1:0]         status,
	input wire logic [fbfl_pkg::ADDR_W-1:0]         chunk_address,
	input wire logic [fbfl_pkg::TOTAL_W-1:0]        free_count
);

	import fbfl_pkg::*;

	// held result does not change while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
		&& $stable(chunk_address) && $stable(free_count))
		else $error("result changed while stalled");

	// only an allocated chunk carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_ALLOCATED |-> chunk_address == '0)
		else $error("address on a non-allocate result");

	// one transaction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while busy");

	// a register write starts the relink sweep
	a_cfg_relink: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == CFG_CHUNK_SIZE || cfg_index == CFG_TOTAL
		|| cfg_index == CFG_BASE) |=> !in_ready)
		else $error("ready during relink");

endmodule

bind fixed_block_free_list_allocator_top fbfl_chk u_fbfl_chk (.*);

`default_nettype wire

/* test/fixed_block_free_list_allocator_top_test.sv */
// self-checking testbench of the fixed block free list allocator top level
// predicts every result from its own free list model; needs fbfl_pkg and the rtl
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_top_test;
	import fbfl_pkg::*;

	localparam int unsigned MAX_CHUNKS     = 1024;
	localparam int unsigned WATCHDOG_LIMIT = 10000;
	localparam int unsigned RANDOM_PHASES  = 12;
	localparam int unsigned PHASE_ITEMS    = 115;
	localparam int unsigned CALM_PHASES    = 2;
	localparam int unsigned REPORT_LIMIT   = 10;
	localparam int unsigned ALIGN_BYTES    = 4;
	localparam int unsigned MIN_BYTES      = 8;

	// request kinds
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// index with no register behind it: the write must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		status_t             sts;
		logic [ADDR_W-1:0]   addr;
		logic [TOTAL_W-1:0]  cnt;
	} alloc_result_t;

	// free list model plus the queue of results it has promised
	class free_list_scoreboard;
		logic [CSIZE_W-1:0]  size_req;
		logic [TOTAL_W-1:0]  total_req;
		logic [ADDR_W-1:0]   base;
		logic [TOTAL_W-1:0]  link_idx [MAX_CHUNKS];
		bit                  link_ok [MAX_CHUNKS];
		logic [TOTAL_W-1:0]  head;
		bit                  head_ok;
		int unsigned         n_free;
		alloc_result_t       pending_results [$];
		logic [ADDR_W-1:0]   live_chunks [$];
		int unsigned         failures;

		// request rounded up to whole words, never below a pointer
		function longint unsigned chunk_bytes();
			longint unsigned s;
			s = ((longint'(size_req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
			return (s < MIN_BYTES) ? MIN_BYTES : s;
		endfunction

		function longint unsigned chunk_total();
			return (total_req > MAX_CHUNKS) ? MAX_CHUNKS : total_req;
		endfunction

		// every chunk free, linked in ascending order from chunk zero
		function void relink();
			longint unsigned n;
			n = chunk_total();
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				link_ok[i] = (i + 1 < n);
				link_idx[i] = link_ok[i] ? TOTAL_W'(i + 1) : '0;
			end
			head = '0;
			head_ok = (n != 0);
			n_free = n;
			live_chunks.delete();
		endfunction

		function void power_on();
			size_req = CSIZE_RST;
			total_req = TOTAL_RST;
			base = BASE_RST;
			failures = 0;
			relink();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CHUNK_SIZE: size_req = data[CSIZE_W-1:0];
				CFG_TOTAL:      total_req = data[TOTAL_W-1:0];
				CFG_BASE:       base = data;
				default:        return;
			endcase
			relink();
		endfunction

		function void note_request(logic m, logic [REQ_W-1:0] rq, logic nl,
				logic [ADDR_W-1:0] ad);
			longint unsigned csize, ctotal, off, idx;
			alloc_result_t res;
			csize = chunk_bytes();
			ctotal = chunk_total();
			res.addr = '0;
			if (m == MODE_ALLOC) begin
				if (rq > csize) begin
					res.sts = STS_TOO_LARGE;
				end else if (!head_ok) begin
					res.sts = STS_EXHAUSTED;
				end else begin
					// pop the head; the address wraps at 32 bits
					idx = head;
					res.addr = ADDR_W'(base + idx * csize);
					res.sts = STS_ALLOCATED;
					head_ok = link_ok[idx];
					head = link_idx[idx];
					if (n_free > 0) n_free--;
				end
			end else if (nl) begin
				res.sts = STS_NULL;
			end else if (ad < base || ad >= base + csize * ctotal) begin
				// pool end taken exactly, no wrap
				res.sts = STS_OUT_RANGE;
			end else begin
				off = ad - base;
				idx = off / csize;
				if (off % csize != 0 || idx >= MAX_CHUNKS) begin
					res.sts = STS_MISALIGNED;
				end else begin
					// push back on the head, double frees included
					link_idx[idx] = head;
					link_ok[idx] = head_ok;
					head = TOTAL_W'(idx);
					head_ok = 1'b1;
					if (n_free < ctotal) n_free++;
					res.sts = STS_FREED;
				end
			end
			res.cnt = TOTAL_W'(n_free);
			pending_results = {pending_results, res};
		endfunction

		function void check_result(logic [STAT_W-1:0] sts, logic [ADDR_W-1:0] addr,
				logic [TOTAL_W-1:0] cnt);
			alloc_result_t exp_res;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result with nothing outstanding, status %0d", $time, sts);
				return;
			end
			exp_res = pending_results.pop_front();
			if (sts !== exp_res.sts || addr !== exp_res.addr || cnt !== exp_res.cnt) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: mismatch status %0d/%0d addr %h/%h free %0d/%0d (exp/got)",
						$time, exp_res.sts, sts, exp_res.addr, addr, exp_res.cnt, cnt);
			end
			if (exp_res.sts == STS_ALLOCATED) live_chunks = {live_chunks, exp_res.addr};
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	wire                    in_ready;
	logic                   mode = MODE_ALLOC;
	logic [REQ_W-1:0]       request_size = '0;
	logic                   null_pointer = 1'b0;
	logic [ADDR_W-1:0]      free_address = '0;
	wire                    out_valid;
	logic                   out_ready = 1'b0;
	wire  [STAT_W-1:0]      status;
	wire  [ADDR_W-1:0]      chunk_address;
	wire  [TOTAL_W-1:0]     free_count;

	free_list_scoreboard    sb;
	bit                     rx_stalls = 1'b1;
	bit                     calm = 1'b0;
	int unsigned            quiet_cycles = 0;

	fixed_block_free_list_allocator_top #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.request_size(request_size),
		.null_pointer(null_pointer),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.chunk_address(chunk_address),
		.free_count(free_count)
	);

	always #2 clk = ~clk;

	// transactions on both channels are sampled at the edge that completes them;
	// results first, though an item never finishes on its own accept edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(status, chunk_address, free_count);
			if (in_valid && in_ready)
				sb.note_request(mode, request_size, null_pointer, free_address);
		end
	end

	// watchdog: any transaction or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// result side back-pressure: random stall bursts, off in quiet phases
	initial begin
		@(posedge clk);
		forever begin
			if (rx_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// one register write; a real write starts a relink sweep that holds in_ready
	// low, so wait for the block to come back before anything else
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// called right after an edge; returns on the edge that accepts the item
	// with in_valid still high so a back-to-back item needs only one assignment
	task automatic send_item(input logic m, input logic [REQ_W-1:0] rq, input logic nl,
			input logic [ADDR_W-1:0] ad);
		in_valid <= 1'b1;
		mode <= m;
		request_size <= rq;
		null_pointer <= nl;
		free_address <= ad;
		do @(posedge clk); while (!in_ready);
	endtask

	// everything outstanding back; the first edge lets the monitor note an item
	// accepted on the edge just passed
	task automatic settle();
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		settle();
	endtask

	// new random pool shape; sizes and counts stay small most of the time
	task automatic reconfigure_pool();
		logic [CFG_DATA_W-1:0] data;
		int unsigned mask;
		mask = $urandom_range(1, 7);
		if (mask[0]) begin
			data = $urandom();
			case ($urandom_range(0, 9))
				0: data[CSIZE_W-1:0] = '0;
				1: data[CSIZE_W-1:0] = '1;
				2: ;
				3: data[CSIZE_W-1:0] = CSIZE_W'(1);
				default: data[CSIZE_W-1:0] = CSIZE_W'($urandom_range(1, 48));
			endcase
			cfg_write(CFG_CHUNK_SIZE, data);
		end
		if (mask[1]) begin
			data = $urandom();
			case ($urandom_range(0, 9))
				0: data[TOTAL_W-1:0] = '0;
				1: data[TOTAL_W-1:0] = TOTAL_W'($urandom_range(MAX_CHUNKS, 2047));
				2: data[TOTAL_W-1:0] = TOTAL_W'(MAX_CHUNKS);
				default: data[TOTAL_W-1:0] = TOTAL_W'($urandom_range(1, 12));
			endcase
			cfg_write(CFG_TOTAL, data);
		end
		if (mask[2]) begin
			case ($urandom_range(0, 5))
				0: data = '0;
				1: data = 32'hFFFF_FFFF - $urandom_range(0, 1023);
				default: data = $urandom();
			endcase
			cfg_write(CFG_BASE, data);
		end
		if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, $urandom());
	endtask

	// random traffic; frees often hand back chunks that were handed out, the rest
	// use a null pointer, an aligned or misaligned pool address, a bound or a random one
	task automatic run_burst(input int unsigned n_items, input bit gaps);
		longint unsigned csize, ctotal, aligned;
		logic m, nl;
		logic [REQ_W-1:0] rq;
		logic [ADDR_W-1:0] ad;
		int unsigned pick, alloc_pct, k, slot;
		bit hold_gap, hold_drain;
		alloc_pct = $urandom_range(30, 70);
		for (int unsigned i = 0; i < n_items; i++) begin
			csize = sb.chunk_bytes();
			ctotal = sb.chunk_total();
			m = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
			rq = $urandom();
			nl = 1'b0;
			ad = $urandom();
			pick = $urandom_range(0, 99);
			if (m == MODE_ALLOC) begin
				if (pick < 75)
					rq = REQ_W'($urandom_range(0, csize));
				else if (pick < 90)
					rq = REQ_W'(csize + 1);
				else if (pick < 95)
					rq = '1;
			end else begin
				k = (ctotal != 0) ? $urandom_range(0, ctotal - 1) : 0;
				aligned = sb.base + k * csize;
				if (pick < 5) begin
					nl = 1'b1;
				end else if (pick < 50 && sb.live_chunks.size() != 0) begin
					slot = $urandom_range(0, sb.live_chunks.size() - 1);
					ad = sb.live_chunks[slot];
					sb.live_chunks.delete(slot);
				end else if (pick < 70) begin
					ad = ADDR_W'(aligned);
				end else if (pick < 82) begin
					ad = ADDR_W'(aligned + $urandom_range(1, csize - 1));
				end else if (pick < 87) begin
					ad = sb.base - 1;
				end else if (pick < 92) begin
					ad = ADDR_W'(sb.base + csize * ctotal);
				end
			end
			// halfway through, hold off until the block has answered everything
			hold_drain = (i == n_items / 2);
			hold_gap = gaps && ($urandom_range(0, 3) == 0);
			if (hold_gap || hold_drain) begin
				in_valid <= 1'b0;
				if (hold_drain)
					do @(posedge clk); while (sb.pending_results.size() != 0);
				if (hold_gap)
					repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			send_item(m, rq, nl, ad);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		sb = new;
		sb.power_on();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset shape: 36-byte chunks, ten of them, pool at zero
		send_item(MODE_ALLOC, 16'd0, 1'b1, '1);
		send_item(MODE_ALLOC, 16'd36, 1'b0, '1);
		send_item(MODE_ALLOC, 16'd37, 1'b0, '0);
		send_item(MODE_ALLOC, 16'hFFFF, 1'b0, '0);
		// null pointer wins over any address
		send_item(MODE_FREE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd36);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd37);
		// first byte past the pool, then the top of the address space
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd360);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'hFFFF_FFFF);
		// the same chunk twice: second push is not caught, count saturates
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd0);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd0);
		quiesce();

		// zero request becomes 8-byte chunks; two chunks at the very top so the
		// second address wraps and the pool end lies beyond 32 bits
		cfg_write(CFG_BASE, 32'hFFFF_FFFC);
		cfg_write(CFG_CHUNK_SIZE, '0);
		cfg_write(CFG_TOTAL, 32'd2);
		send_item(MODE_ALLOC, 16'd8, 1'b0, '0);
		send_item(MODE_ALLOC, 16'd0, 1'b0, '0);
		send_item(MODE_ALLOC, 16'd0, 1'b0, '0);
		send_item(MODE_ALLOC, 16'd9, 1'b0, '0);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'hFFFF_FFFC + 32'd4);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'hFFFF_FFFC);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd4);
		quiesce();

		// empty pool
		cfg_write(CFG_TOTAL, '0);
		send_item(MODE_ALLOC, 16'd0, 1'b0, '0);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'hFFFF_FFFC);
		quiesce();

		// largest chunk request and a chunk count above the maximum
		cfg_write(CFG_CHUNK_SIZE, 32'd8191);
		cfg_write(CFG_TOTAL, 32'd2047);
		cfg_write(CFG_BASE, '0);
		send_item(MODE_ALLOC, 16'd8192, 1'b0, '0);
		send_item(MODE_ALLOC, 16'hFFFF, 1'b0, '0);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd8192 * 32'd1023);
		send_item(MODE_ALLOC, 16'd1, 1'b0, '0);
		send_item(MODE_FREE, 16'd0, 1'b0, 32'd8192 * 32'd1024);
		quiesce();

		// random phases; every fourth one and the last ones run without idling
		for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
			reconfigure_pool();
			calm = (ph >= RANDOM_PHASES - CALM_PHASES) || (ph % 4 == 3);
			rx_stalls = !calm;
			run_burst(PHASE_ITEMS, !calm);
			settle();
		end

		repeat (40) @(posedge clk);
		if (sb.failures == 0 && sb.pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
